### hw/rtl/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg: shared types and helpers for the circle pair contact pipeline
// Holds the field widths, the geometry record that rides the pipeline and
// the saturating narrowing function.
// ----------------------------------------------------------------------------
package ccc_pkg;

   // Default number of fraction bits of the fixed-point format.
   localparam int FRAC_BITS_DEF = 16;

   // Iterations of the square root and of the divider.
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;

   // Width of one product of a radius and a centre distance component.
   localparam int PROD_W = 63;

   // Geometry of one pair, carried alongside the long arithmetic.
   typedef struct packed {
      logic signed [32:0] ax;
      logic signed [32:0] ay;
      logic signed [32:0] bx;
      logic signed [32:0] by;
      logic [30:0]        ra;
      logic [30:0]        rb;
      logic [31:0]        rsum;
      logic               dx_neg;
      logic               dy_neg;
      logic               hit;
      logic               zero;
   } geom_type;

   // Narrow a wide signed value to 32 bits with saturation.
   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/ccc_front.sv
// ----------------------------------------------------------------------------
// ccc_front: world centres, scaled radii and the overlap test
// Four register stages: sums and radius products, saturation and deltas,
// squares and offset products, then the squared distance compare.
// ----------------------------------------------------------------------------
module ccc_front #(
   parameter int FRAC_BITS = ccc_pkg::FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [31:0]      a_center_x,
   input  logic signed [31:0]      a_center_y,
   input  logic signed [31:0]      a_pos_x,
   input  logic signed [31:0]      a_pos_y,
   input  logic [30:0]             a_radius,
   input  logic [30:0]             a_scale,
   input  logic signed [31:0]      b_center_x,
   input  logic signed [31:0]      b_center_y,
   input  logic signed [31:0]      b_pos_x,
   input  logic signed [31:0]      b_pos_y,
   input  logic [30:0]             b_radius,
   input  logic [30:0]             b_scale,
   output logic                    out_valid,
   output ccc_pkg::geom_type       out_geom,
   output logic [63:0]             out_dsq,
   output logic [3:0][ccc_pkg::PROD_W-1:0] out_prod
);

   // Stage 1: world centres and raw radius products.
   logic               v1_ff;
   logic signed [32:0] ax1_ff, ay1_ff, bx1_ff, by1_ff;
   logic [61:0]        pa1_ff, pb1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ax1_ff <= 33'(a_center_x) + 33'(a_pos_x);
         ay1_ff <= 33'(a_center_y) + 33'(a_pos_y);
         bx1_ff <= 33'(b_center_x) + 33'(b_pos_x);
         by1_ff <= 33'(b_center_y) + 33'(b_pos_y);
         pa1_ff <= 62'(a_radius) * 62'(a_scale);
         pb1_ff <= 62'(b_radius) * 62'(b_scale);
      end
   end

   // Stage 2: saturated scaled radii, centre deltas and their magnitudes.
   logic [61:0]        pa_sh, pb_sh;
   logic [30:0]        ra_in, rb_in;
   logic signed [33:0] dx_in, dy_in;
   logic               v2_ff;
   logic signed [32:0] ax2_ff, ay2_ff, bx2_ff, by2_ff;
   logic [30:0]        ra2_ff, rb2_ff;
   logic [31:0]        rsum2_ff;
   logic [33:0]        mx2_ff, my2_ff;
   logic               dxn2_ff, dyn2_ff;

   always_comb begin
      pa_sh = pa1_ff >> FRAC_BITS;
      pb_sh = pb1_ff >> FRAC_BITS;
      ra_in = (pa_sh > 62'h7FFFFFFF) ? 31'h7FFFFFFF : pa_sh[30:0];
      rb_in = (pb_sh > 62'h7FFFFFFF) ? 31'h7FFFFFFF : pb_sh[30:0];
      dx_in = 34'(bx1_ff) - 34'(ax1_ff);
      dy_in = 34'(by1_ff) - 34'(ay1_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax2_ff   <= ax1_ff;
         ay2_ff   <= ay1_ff;
         bx2_ff   <= bx1_ff;
         by2_ff   <= by1_ff;
         ra2_ff   <= ra_in;
         rb2_ff   <= rb_in;
         rsum2_ff <= 32'(ra_in) + 32'(rb_in);
         mx2_ff   <= dx_in[33] ? 34'(-dx_in) : 34'(dx_in);
         my2_ff   <= dy_in[33] ? 34'(-dy_in) : 34'(dy_in);
         dxn2_ff  <= dx_in[33];
         dyn2_ff  <= dy_in[33];
      end
   end

   // Stage 3: far test, squares and the radius times delta products.
   logic              v3_ff;
   ccc_pkg::geom_type g3_ff;
   logic              far3_ff;
   logic [63:0]       sx3_ff, sy3_ff, rsq3_ff;
   logic [3:0][ccc_pkg::PROD_W-1:0] prod3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         g3_ff.ax     <= ax2_ff;
         g3_ff.ay     <= ay2_ff;
         g3_ff.bx     <= bx2_ff;
         g3_ff.by     <= by2_ff;
         g3_ff.ra     <= ra2_ff;
         g3_ff.rb     <= rb2_ff;
         g3_ff.rsum   <= rsum2_ff;
         g3_ff.dx_neg <= dxn2_ff;
         g3_ff.dy_neg <= dyn2_ff;
         g3_ff.hit    <= 1'b0;
         g3_ff.zero   <= 1'b0;
         far3_ff      <= (mx2_ff > 34'(rsum2_ff)) || (my2_ff > 34'(rsum2_ff));
         sx3_ff       <= 64'(mx2_ff[31:0]) * 64'(mx2_ff[31:0]);
         sy3_ff       <= 64'(my2_ff[31:0]) * 64'(my2_ff[31:0]);
         rsq3_ff      <= 64'(rsum2_ff) * 64'(rsum2_ff);
         prod3_ff[0]  <= 63'(ra2_ff) * 63'(mx2_ff[31:0]);
         prod3_ff[1]  <= 63'(ra2_ff) * 63'(my2_ff[31:0]);
         prod3_ff[2]  <= 63'(rb2_ff) * 63'(mx2_ff[31:0]);
         prod3_ff[3]  <= 63'(rb2_ff) * 63'(my2_ff[31:0]);
      end
   end

   // Stage 4: exact squared distance against the squared radius sum.
   logic [64:0]       dsq_in;
   ccc_pkg::geom_type g4_in;
   logic              v4_ff;
   ccc_pkg::geom_type g4_ff;
   logic [63:0]       dsq4_ff;
   logic [3:0][ccc_pkg::PROD_W-1:0] prod4_ff;

   assign dsq_in = 65'(sx3_ff) + 65'(sy3_ff);

   always_comb begin
      g4_in      = g3_ff;
      g4_in.hit  = !far3_ff && (dsq_in <= 65'(rsq3_ff));
      g4_in.zero = (dsq_in == 65'd0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g4_ff    <= g4_in;
         dsq4_ff  <= dsq_in[63:0];
         prod4_ff <= prod3_ff;
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_geom  = g4_ff;
   assign out_dsq   = dsq4_ff;
   assign out_prod  = prod4_ff;

endmodule

### hw/rtl/ccc_sqrt.sv
// ----------------------------------------------------------------------------
// ccc_sqrt: pipelined integer square root
// One root bit per stage, restoring form, with a side word carried along.
// ----------------------------------------------------------------------------
module ccc_sqrt #(
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [63:0]   radicand,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [31:0]   root,
   output logic [SW-1:0] out_side
);

   localparam int N = ccc_pkg::SQRT_STEPS;

   logic [63:0]   rad_ff  [0:N-1];
   logic [33:0]   rem_ff  [0:N-1];
   logic [31:0]   root_ff [0:N-1];
   logic [SW-1:0] side_ff [0:N-1];
   logic [N-1:0]  v_ff;

   for (genvar i = 0; i < N; i++) begin : g_step
      logic [63:0]   rad_p;
      logic [33:0]   rem_p;
      logic [31:0]   root_p;
      logic [SW-1:0] side_p;
      logic          v_p;
      logic [35:0]   t, trial, diff;
      logic          ge;

      if (i == 0) begin : g_first
         assign rad_p  = radicand;
         assign rem_p  = '0;
         assign root_p = '0;
         assign side_p = in_side;
         assign v_p    = in_valid;
      end else begin : g_next
         assign rad_p  = rad_ff[i-1];
         assign rem_p  = rem_ff[i-1];
         assign root_p = root_ff[i-1];
         assign side_p = side_ff[i-1];
         assign v_p    = v_ff[i-1];
      end

      // Bring down two radicand bits and try the next root bit.
      always_comb begin
         t     = {rem_p, rad_p[63:62]};
         trial = {2'b00, root_p, 2'b01};
         ge    = (t >= trial);
         diff  = t - trial;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[i]  <= {rad_p[61:0], 2'b00};
            rem_ff[i]  <= ge ? diff[33:0] : t[33:0];
            root_ff[i] <= {root_p[30:0], ge};
            side_ff[i] <= side_p;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_p;
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign root      = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

### hw/rtl/ccc_div.sv
// ----------------------------------------------------------------------------
// ccc_div: four-lane pipelined divider by the centre distance
// One quotient bit per stage per lane; the quotient is known to fit in 31 bits,
// so the top half of each dividend is already below the divisor.
// ----------------------------------------------------------------------------
module ccc_div #(
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [3:0][ccc_pkg::PROD_W-1:0] dividend,
   input  logic [31:0]   divisor,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [3:0][30:0] quotient,
   output logic [31:0]   out_divisor,
   output logic [SW-1:0] out_side
);

   localparam int N = ccc_pkg::DIV_STEPS;

   logic [3:0][31:0] rem_ff  [0:N-1];
   logic [3:0][30:0] low_ff  [0:N-1];
   logic [3:0][30:0] quo_ff  [0:N-1];
   logic [31:0]      dvs_ff  [0:N-1];
   logic [SW-1:0]    side_ff [0:N-1];
   logic [N-1:0]     v_ff;

   for (genvar i = 0; i < N; i++) begin : g_step
      logic [3:0][31:0] rem_p, rem_n;
      logic [3:0][30:0] low_p, quo_p;
      logic [31:0]      dvs_p;
      logic [SW-1:0]    side_p;
      logic             v_p;
      logic [3:0]       ge;

      if (i == 0) begin : g_first
         for (genvar l = 0; l < 4; l++) begin : g_lane
            assign rem_p[l] = dividend[l][62:31];
            assign low_p[l] = dividend[l][30:0];
         end
         assign quo_p  = '0;
         assign dvs_p  = divisor;
         assign side_p = in_side;
         assign v_p    = in_valid;
      end else begin : g_next
         assign rem_p  = rem_ff[i-1];
         assign low_p  = low_ff[i-1];
         assign quo_p  = quo_ff[i-1];
         assign dvs_p  = dvs_ff[i-1];
         assign side_p = side_ff[i-1];
         assign v_p    = v_ff[i-1];
      end

      // Shift in the next dividend bit and subtract where it fits.
      always_comb begin
         logic [32:0] t;
         logic [32:0] d;
         for (int l = 0; l < 4; l++) begin
            t        = {rem_p[l], low_p[l][30]};
            ge[l]    = (t >= {1'b0, dvs_p});
            d        = t - {1'b0, dvs_p};
            rem_n[l] = ge[l] ? d[31:0] : t[31:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < 4; l++) begin
               rem_ff[i][l] <= rem_n[l];
               low_ff[i][l] <= {low_p[l][29:0], 1'b0};
               quo_ff[i][l] <= {quo_p[l][29:0], ge[l]};
            end
            dvs_ff[i]  <= dvs_p;
            side_ff[i] <= side_p;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_p;
         end
      end
   end

   assign out_valid   = v_ff[N-1];
   assign quotient    = quo_ff[N-1];
   assign out_divisor = dvs_ff[N-1];
   assign out_side    = side_ff[N-1];

endmodule

### hw/rtl/ccc_back.sv
// ----------------------------------------------------------------------------
// ccc_back: contact points, normal and depth, into the output register
// Applies the signed offsets, handles coincident centres and misses, and
// saturates every field to 32 bits.
// ----------------------------------------------------------------------------
module ccc_back #(
   parameter int FRAC_BITS = ccc_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  ccc_pkg::geom_type  geom,
   input  logic [31:0]        ctr_dist,
   input  logic [3:0][30:0]   offset,
   output logic               out_valid,
   output logic signed [31:0] contact_a_x,
   output logic signed [31:0] contact_a_y,
   output logic signed [31:0] contact_b_x,
   output logic signed [31:0] contact_b_y,
   output logic signed [31:0] normal_x,
   output logic signed [31:0] normal_y,
   output logic signed [31:0] depth,
   output logic               hit
);

   logic signed [32:0] oax, oay, obx, oby;
   logic signed [35:0] cax, cay, cbx, cby;
   logic [31:0]        dep_raw;
   logic signed [31:0] cax_in, cay_in, cbx_in, cby_in, nx_in, ny_in, dep_in;

   // Signed offsets along the centre line.
   always_comb begin
      oax = geom.dx_neg ? -33'(offset[0]) : 33'(offset[0]);
      oay = geom.dy_neg ? -33'(offset[1]) : 33'(offset[1]);
      obx = geom.dx_neg ? -33'(offset[2]) : 33'(offset[2]);
      oby = geom.dy_neg ? -33'(offset[3]) : 33'(offset[3]);
      cax = 36'(geom.ax) + 36'(oax);
      cay = 36'(geom.ay) + 36'(oay);
      cbx = 36'(geom.bx) - 36'(obx);
      cby = 36'(geom.by) - 36'(oby);
      dep_raw = geom.rsum - ctr_dist;
   end

   // Select between a miss, coincident centres and the general contact.
   always_comb begin
      priority if (!geom.hit) begin
         cax_in = '0;
         cay_in = '0;
         cbx_in = '0;
         cby_in = '0;
         nx_in  = '0;
         ny_in  = '0;
         dep_in = '0;
      end else if (geom.zero) begin
         cax_in = ccc_pkg::sat32(36'(geom.ax));
         cay_in = ccc_pkg::sat32(36'(geom.ay) + 36'(geom.ra));
         cbx_in = ccc_pkg::sat32(36'(geom.bx));
         cby_in = ccc_pkg::sat32(36'(geom.by) + 36'(geom.rb));
         nx_in  = '0;
         ny_in  = 32'(1) <<< FRAC_BITS;
         dep_in = (geom.ra > geom.rb) ? 32'(geom.ra) : 32'(geom.rb);
      end else begin
         cax_in = ccc_pkg::sat32(cax);
         cay_in = ccc_pkg::sat32(cay);
         cbx_in = ccc_pkg::sat32(cbx);
         cby_in = ccc_pkg::sat32(cby);
         // The normal comes from the unsaturated contact points.
         nx_in  = ccc_pkg::sat32(cbx - cax);
         ny_in  = ccc_pkg::sat32(cby - cay);
         dep_in = dep_raw[31] ? 32'sh7FFFFFFF : dep_raw;
      end
   end

   // Output register.
   logic               v_ff;
   logic signed [31:0] cax_ff, cay_ff, cbx_ff, cby_ff, nx_ff, ny_ff, dep_ff;
   logic               hit_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cax_ff <= cax_in;
         cay_ff <= cay_in;
         cbx_ff <= cbx_in;
         cby_ff <= cby_in;
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
         dep_ff <= dep_in;
         hit_ff <= geom.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   assign out_valid   = v_ff;
   assign contact_a_x = cax_ff;
   assign contact_a_y = cay_ff;
   assign contact_b_x = cbx_ff;
   assign contact_b_y = cby_ff;
   assign normal_x    = nx_ff;
   assign normal_y    = ny_ff;
   assign depth       = dep_ff;
   assign hit         = hit_ff;

endmodule

### hw/rtl/circle_circle_contact_top.sv
// ----------------------------------------------------------------------------
// circle_circle_contact_top: pipelined contact test between two circles
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_ready   two circles: centre, position,
//                                             radius and x scale each
// rsp      out        rsp_valid / rsp_ready   contacts, normal, depth, hit
// One item enters per cycle unless the output stalls; each item passes through
// 4 front stages, 32 square root stages, 31 divider stages and the output
// register on its way from acceptance to its result.
// Reset is synchronous and clears only the valid bits.
// A result held at the output stalls the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module circle_circle_contact_top #(
   parameter int FRAC_BITS = ccc_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_a_center_x,
   input  logic signed [31:0] req_a_center_y,
   input  logic signed [31:0] req_a_pos_x,
   input  logic signed [31:0] req_a_pos_y,
   input  logic [30:0]        req_a_radius,
   input  logic [30:0]        req_a_scale,
   input  logic signed [31:0] req_b_center_x,
   input  logic signed [31:0] req_b_center_y,
   input  logic signed [31:0] req_b_pos_x,
   input  logic signed [31:0] req_b_pos_y,
   input  logic [30:0]        req_b_radius,
   input  logic [30:0]        req_b_scale,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_contact_a_x,
   output logic signed [31:0] rsp_contact_a_y,
   output logic signed [31:0] rsp_contact_b_x,
   output logic signed [31:0] rsp_contact_b_y,
   output logic signed [31:0] rsp_normal_x,
   output logic signed [31:0] rsp_normal_y,
   output logic signed [31:0] rsp_depth,
   output logic               rsp_hit
);

   localparam int GW    = $bits(ccc_pkg::geom_type);
   localparam int SQ_SW = GW + 4 * ccc_pkg::PROD_W;

   // The pipeline advances unless a result is waiting at the output.
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // Front stages.
   logic              fr_valid;
   ccc_pkg::geom_type fr_geom;
   logic [63:0]       fr_dsq;
   logic [3:0][ccc_pkg::PROD_W-1:0] fr_prod;

   ccc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_valid && req_ready),
      .a_center_x (req_a_center_x),
      .a_center_y (req_a_center_y),
      .a_pos_x    (req_a_pos_x),
      .a_pos_y    (req_a_pos_y),
      .a_radius   (req_a_radius),
      .a_scale    (req_a_scale),
      .b_center_x (req_b_center_x),
      .b_center_y (req_b_center_y),
      .b_pos_x    (req_b_pos_x),
      .b_pos_y    (req_b_pos_y),
      .b_radius   (req_b_radius),
      .b_scale    (req_b_scale),
      .out_valid  (fr_valid),
      .out_geom   (fr_geom),
      .out_dsq    (fr_dsq),
      .out_prod   (fr_prod)
   );

   // Distance by square root, geometry and products riding along.
   logic              sq_valid;
   logic [31:0]       sq_root;
   logic [SQ_SW-1:0]  sq_side;
   ccc_pkg::geom_type sq_geom;
   logic [3:0][ccc_pkg::PROD_W-1:0] sq_prod;

   ccc_sqrt #(.SW(SQ_SW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .radicand  (fr_dsq),
      .in_side   ({fr_geom, fr_prod}),
      .out_valid (sq_valid),
      .root      (sq_root),
      .out_side  (sq_side)
   );

   assign {sq_geom, sq_prod} = sq_side;

   // Offsets along the centre line.
   logic              dv_valid;
   logic [3:0][30:0]  dv_quo;
   logic [31:0]       dv_dist;
   logic [GW-1:0]     dv_side;

   ccc_div #(.SW(GW)) u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (sq_valid),
      .dividend    (sq_prod),
      .divisor     (sq_root),
      .in_side     (sq_geom),
      .out_valid   (dv_valid),
      .quotient    (dv_quo),
      .out_divisor (dv_dist),
      .out_side    (dv_side)
   );

   // Final arithmetic and the output register.
   ccc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (dv_valid),
      .geom        (ccc_pkg::geom_type'(dv_side)),
      .ctr_dist    (dv_dist),
      .offset      (dv_quo),
      .out_valid   (rsp_valid),
      .contact_a_x (rsp_contact_a_x),
      .contact_a_y (rsp_contact_a_y),
      .contact_b_x (rsp_contact_b_x),
      .contact_b_y (rsp_contact_b_y),
      .normal_x    (rsp_normal_x),
      .normal_y    (rsp_normal_y),
      .depth       (rsp_depth),
      .hit         (rsp_hit)
   );

`ifndef SYNTHESIS
   // An empty output never blocks the input.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked while output empty");

   // A miss carries all-zero fields.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_contact_a_x == 0 && rsp_contact_a_y == 0 &&
         rsp_contact_b_x == 0 && rsp_contact_b_y == 0 && rsp_normal_x == 0 &&
         rsp_normal_y == 0 && rsp_depth == 0))
      else $error("miss with non-zero fields");

   // Depth of a hit is never negative.
   a_depth_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_depth[31])
      else $error("negative depth on a hit");
`endif

endmodule
